### hdl/cps_pkg.sv
// ----------------------------------------------------------------------------
// Cumulative product scan: shared definitions
// Register indexes, fixed field widths and the step flags passed from the
// position sequencer to the datapath.
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int VALUE_W       = 32;
   localparam int INNER_SIZE_W  = 11;
   localparam int SCAN_LENGTH_W = 16;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_INNER_SIZE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCAN_LENGTH = 8'd1;

   typedef struct packed {
      logic first;
      logic slab_end;
   } cps_step_type;

endpackage

### hdl/cps_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module cps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/cps_seq.sv
// ----------------------------------------------------------------------------
// Cumulative product scan: position sequencer
// Holds the two configuration registers and the inner and axis counters, and
// reports the store position and step flags of the next beat.
// ----------------------------------------------------------------------------
module cps_seq #(
   parameter int INNER_DEPTH = 1024
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              csr_we,
   input  logic [cps_pkg::CSR_INDEX_W-1:0]                   csr_index,
   input  logic [cps_pkg::CSR_DATA_W-1:0]                    csr_wdata,
   input  logic                                              advance,
   output logic [(INNER_DEPTH > 1 ? $clog2(INNER_DEPTH) : 1)-1:0] pos,
   output cps_pkg::cps_step_type                             step
);
   import cps_pkg::*;

   localparam int IDX_W = INNER_DEPTH > 1 ? $clog2(INNER_DEPTH) : 1;
   localparam int CNT_W = $clog2(INNER_DEPTH + 1);
   localparam int EW    = (CNT_W > INNER_SIZE_W ? CNT_W : INNER_SIZE_W) + 1;
   localparam int AW    = SCAN_LENGTH_W + 1;

   logic [INNER_SIZE_W-1:0]  inner_size_ff, inner_size_in;
   logic [SCAN_LENGTH_W-1:0] scan_length_ff, scan_length_in;
   logic [IDX_W-1:0]         inner_ff, inner_in;
   logic [SCAN_LENGTH_W-1:0] axis_ff, axis_in;

   logic [EW-1:0] size_ext;
   logic [EW-1:0] eff_inner;
   logic [EW-1:0] pos_next;
   logic [AW-1:0] eff_scan;
   logic [AW-1:0] axis_next;
   logic          inner_wrap;
   logic          axis_last;

   always_comb begin
      size_ext = EW'(inner_size_ff);
      if (size_ext == '0) begin
         eff_inner = EW'(1);
      end else if (size_ext > EW'(INNER_DEPTH)) begin
         eff_inner = EW'(INNER_DEPTH);
      end else begin
         eff_inner = size_ext;
      end
      eff_scan   = (scan_length_ff == '0) ? AW'(1) : AW'(scan_length_ff);
      pos_next   = EW'(inner_ff) + EW'(1);
      axis_next  = AW'(axis_ff) + AW'(1);
      inner_wrap = pos_next >= eff_inner;
      axis_last  = axis_next >= eff_scan;
   end

   always_comb begin
      inner_size_in  = inner_size_ff;
      scan_length_in = scan_length_ff;
      inner_in       = inner_ff;
      axis_in        = axis_ff;
      if (csr_we) begin
         case (csr_index)
            REG_INNER_SIZE: begin
               inner_size_in = csr_wdata[INNER_SIZE_W-1:0];
               inner_in      = '0;
               axis_in       = '0;
            end
            REG_SCAN_LENGTH: begin
               scan_length_in = csr_wdata[SCAN_LENGTH_W-1:0];
               inner_in       = '0;
               axis_in        = '0;
            end
            default: begin
               inner_in = inner_ff;
            end
         endcase
      end else if (advance) begin
         if (inner_wrap) begin
            inner_in = '0;
            axis_in  = axis_last ? '0 : axis_next[SCAN_LENGTH_W-1:0];
         end else begin
            inner_in = pos_next[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_size_ff  <= INNER_SIZE_W'(1);
         scan_length_ff <= SCAN_LENGTH_W'(1);
         inner_ff       <= '0;
         axis_ff        <= '0;
      end else begin
         inner_size_ff  <= inner_size_in;
         scan_length_ff <= scan_length_in;
         inner_ff       <= inner_in;
         axis_ff        <= axis_in;
      end
   end

   assign pos           = inner_ff;
   assign step.first    = axis_ff == '0;
   assign step.slab_end = inner_wrap && axis_last;

   // The counters never run past the configured shape.
   a_inner_in_range: assert property (@(posedge clock) disable iff (reset)
      EW'(inner_ff) < eff_inner)
      else $error("inner position beyond the inner size");

   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      AW'(axis_ff) < eff_scan)
      else $error("axis step beyond the scan length");

endmodule

### hdl/cumulative_product_scan.sv
// ----------------------------------------------------------------------------
// Cumulative product scan
// Running product of a row-major tensor stream along one axis, with one
// stored partial product per inner position.
//
//   Channel   Direction  Signals                          Purpose
//   req       in         req_valid/ready, req_value       tensor elements
//   rsp       out        rsp_valid/ready, rsp_product,    running products
//                        rsp_end_of_slab
//   csr       in         csr_we, csr_index, csr_wdata     shape registers
//
// One beat per cycle sustained while rsp_ready is held high; each element's result
// passes through the registered store read and then the output register.
// A result reusing the entry written the cycle before is taken from a
// forwarding register. Reset needs no clearing pass: entries are always
// written on the first axis step before they are read. A stalled result
// holds the stage behind it, so at most two elements are in flight.
// ----------------------------------------------------------------------------
module cumulative_product_scan #(
   parameter int INNER_DEPTH = 1024,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cps_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cps_pkg::VALUE_W-1:0]  rsp_product,
   output logic                                rsp_end_of_slab,
   input  logic                                csr_we,
   input  logic [cps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cps_pkg::*;

   localparam int IDX_W = INNER_DEPTH > 1 ? $clog2(INNER_DEPTH) : 1;
   localparam int MUL_W = DATA_WIDTH < VALUE_W ? DATA_WIDTH : VALUE_W;

   logic [IDX_W-1:0] pos;
   cps_step_type     step;
   logic             req_fire;
   logic             s1_adv;

   logic                  s1_valid_ff;
   logic [IDX_W-1:0]      s1_pos_ff;
   cps_step_type          s1_step_ff;
   logic [MUL_W-1:0]      s1_value_ff;
   logic                  fwd_sel_ff;
   logic [DATA_WIDTH-1:0] fwd_data_ff;

   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_product_ff;
   logic                  rsp_end_ff;

   logic [DATA_WIDTH-1:0]    rdata;
   logic [DATA_WIDTH-1:0]    operand;
   logic [MUL_W-1:0]         mul;
   logic [MUL_W-1:0]         prod;
   logic signed [MUL_W-1:0]  prod_s;
   logic [DATA_WIDTH-1:0]    wdata;

   cps_seq #(
      .INNER_DEPTH (INNER_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_fire),
      .pos       (pos),
      .step      (step)
   );

   cps_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (INNER_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_pos_ff),
      .wdata (wdata),
      .re    (req_fire),
      .raddr (pos),
      .rdata (rdata)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      operand = fwd_sel_ff ? fwd_data_ff : rdata;
      mul     = operand[MUL_W-1:0] * s1_value_ff;
      prod    = s1_step_ff.first ? s1_value_ff : mul;
      prod_s  = $signed(prod);
      wdata   = DATA_WIDTH'(prod_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_sel_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            fwd_sel_ff  <= s1_adv && (s1_pos_ff == pos);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pos_ff   <= pos;
         s1_step_ff  <= step;
         s1_value_ff <= req_value[MUL_W-1:0];
         fwd_data_ff <= wdata;
      end
      if (s1_adv) begin
         rsp_product_ff <= VALUE_W'(prod);
         rsp_end_ff     <= s1_step_ff.slab_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_product     = $signed(rsp_product_ff);
   assign rsp_end_of_slab = rsp_end_ff;

   // A back-to-back reuse of the entry just written must take the forwarded value.
   a_forward_taken: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_adv && (s1_pos_ff == pos) |=> fwd_sel_ff)
      else $error("same-entry reuse without forwarding");

   // A held element stays in the stage until the output register frees.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_pos_ff))
      else $error("held element lost from the multiply stage");

endmodule

### verif/tb_cumulative_product_scan.sv
// ----------------------------------------------------------------------------
// Cumulative product scan testbench
// Streams tensor elements through the block under a series of shape settings
// and idling patterns. A scoreboard keeps its own running products per inner
// position and checks every result beat, field by field, in order.
// ----------------------------------------------------------------------------
module tb_cumulative_product_scan;
   import cps_pkg::*;

   localparam int DEPTH         = 1024;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int MAX_PRINTED   = 30;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [VALUE_W-1:0] product;
      logic               end_of_slab;
   } scan_result_type;

   class product_scan_scoreboard;
      logic [VALUE_W-1:0] partial [DEPTH];
      int unsigned        inner_pos;
      int unsigned        axis_pos;
      int unsigned        inner_size;
      int unsigned        scan_length;
      scan_result_type    expected_q [$];
      int                 errors;
      int                 beats_in;
      int                 beats_out;

      function new();
         inner_size  = 1;
         scan_length = 1;
         inner_pos   = 0;
         axis_pos    = 0;
         errors      = 0;
         beats_in    = 0;
         beats_out   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_INNER_SIZE) begin
            inner_size = 32'(data[INNER_SIZE_W-1:0]);
         end else if (idx == REG_SCAN_LENGTH) begin
            scan_length = 32'(data[SCAN_LENGTH_W-1:0]);
         end else begin
            return;
         end
         inner_pos = 0;
         axis_pos  = 0;
      endfunction

      function void note_value(logic [VALUE_W-1:0] v);
         int unsigned     n_inner;
         int unsigned     n_scan;
         int unsigned     pos;
         scan_result_type res;
         n_inner = (inner_size == 0) ? 1 : ((inner_size > DEPTH) ? DEPTH : inner_size);
         n_scan  = (scan_length == 0) ? 1 : scan_length;
         pos     = (inner_pos >= n_inner) ? 0 : inner_pos;
         if (axis_pos == 0) begin
            res.product = v;
         end else begin
            res.product = partial[pos] * v;
         end
         partial[pos]    = res.product;
         res.end_of_slab = (pos + 1 == n_inner) && (axis_pos + 1 >= n_scan);
         expected_q.push_back(res);
         beats_in++;
         if (pos + 1 >= n_inner) begin
            inner_pos = 0;
            axis_pos  = (axis_pos + 1 >= n_scan) ? 0 : axis_pos + 1;
         end else begin
            inner_pos = pos + 1;
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
      endtask

      task check_result(logic [VALUE_W-1:0] product, logic end_of_slab);
         scan_result_type want;
         beats_out++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result beat, product %h", product));
         end else begin
            want = expected_q.pop_front();
            if (product !== want.product)
               report($sformatf("result %0d product %h, wanted %h",
                                beats_out, product, want.product));
            if (end_of_slab !== want.end_of_slab)
               report($sformatf("result %0d end_of_slab %b, wanted %b",
                                beats_out, end_of_slab, want.end_of_slab));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic signed [VALUE_W-1:0]  req_value       = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_product;
   logic                       rsp_end_of_slab;
   logic                       csr_we          = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index       = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata       = '0;

   product_scan_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycles        = 0;
   int settings_used = 0;

   cumulative_product_scan i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_product, rsp_end_of_slab);
         if (req_valid && req_ready) sb.note_value(req_value);
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 54;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 54;
         end
         default: begin
            send_idle_pct = 15;
            rsp_stall_pct = 15;
         end
      endcase
   endtask

   task automatic send_value(logic [VALUE_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_shape(logic [CSR_DATA_W-1:0] inner_w, logic [CSR_DATA_W-1:0] scan_w);
      drain();
      repeat (4) @(posedge clock);
      write_reg(REG_INNER_SIZE, inner_w);
      write_reg(REG_SCAN_LENGTH, scan_w);
      settings_used++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] extremes [5];
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1};
      case ($urandom_range(0, 9))
         0:       return extremes[$urandom_range(0, 4)];
         1, 2, 3: return $urandom_range(0, 16) - 8;
         4, 5, 6: return $urandom | 32'h1;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_directed();
      set_idling(IDLE_BOTH);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      set_shape(16'd2, 16'd3);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h3);
      send_value(32'h0);
      send_value(32'h5);
      send_value(32'hFFFF_FFF9);
      send_value(32'h7);
      // An unlisted register index must leave the scan position alone.
      drain();
      repeat (4) @(posedge clock);
      write_reg(CSR_INDEX_W'($urandom_range(2, 255)), 16'h1234);
      write_reg(8'hFF, 16'hFFFF);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      set_shape(16'd0, 16'd0);
      send_value(32'h1234_5678);
      send_value(32'hFFFF_FFFF);
      set_shape(16'hFFFF, 16'hFFFF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'h0);
   endtask

   task automatic run_random_phase(int phase);
      logic [CSR_DATA_W-1:0] inner_w;
      logic [CSR_DATA_W-1:0] scan_w;
      int                    n_items;
      int                    pause_at;
      if (phase == 0) begin
         inner_w = 16'd1;
         scan_w  = 16'hFFFF;
      end else if (phase == 1) begin
         inner_w = 16'd1024;
         scan_w  = 16'd2;
      end else begin
         inner_w = CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 8));
         scan_w  = CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 8));
      end
      set_shape(inner_w, scan_w);
      set_idling(idle_mode_type'(phase % 4));
      n_items  = $urandom_range(35, 60);
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n_items - 1) : -1;
      for (int i = 0; i < n_items; i++) begin
         if (i == pause_at) drain();
         send_value(pick_value());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);
      drain();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      $display("Checked %0d running products from %0d element beats over %0d shape settings.",
               sb.beats_out, sb.beats_in, settings_used);
      $display("Shapes covered zero, saturated and full-size axes under all idling patterns.");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/cps_pkg.sv
hdl/cps_ram.sv
hdl/cps_seq.sv
hdl/cumulative_product_scan.sv
verif/tb_cumulative_product_scan.sv
